FILE: src/lbs_pkg.sv
// Shared types and constants of the leaky bucket shaper.
package lbs_pkg;

	localparam int BYTE_LANES    = 4;
	localparam int ARRIVAL_LANES = 4;
	localparam int LANES         = (ARRIVAL_LANES < BYTE_LANES) ? ARRIVAL_LANES : BYTE_LANES;
	localparam int LANE_W        = $clog2(BYTE_LANES);
	localparam int DRAIN_MAX     = 4;

	localparam logic [4:0] CAP_RESET   = 5'd10;
	localparam logic [2:0] DRAIN_RESET = 3'd1;

	// register index, taken from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_DRAIN    = 1'b1;

	typedef enum logic [1:0] {
		KIND_SENT    = 2'd0,
		KIND_DROPPED = 2'd1,
		KIND_IDLE    = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload;
		logic [4:0] fill;
		logic       last;
		logic       from_mem;
	} result_t;

endpackage

FILE: src/lbs_ring.sv
// Byte ring store: one write port, one read port, registered read data.
module lbs_ring #(
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold the last read while no new read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/lbs_seq.sv
// Per-tick sequencer: at most one ring access and at most one result per step.
module lbs_seq import lbs_pkg::*; #(
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH),
	localparam int OW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    arrival_count,
	input  logic [7:0]    byte_zero,
	input  logic [7:0]    byte_one,
	input  logic [7:0]    byte_two,
	input  logic [7:0]    byte_three,
	input  logic [4:0]    capacity,
	input  logic [2:0]    drain,
	input  logic          advance,
	output logic          emit,
	output result_t       desc,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0]    mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr
);

	localparam int CW = (OW > 5) ? OW : 5;

	logic          busy_q;
	logic [2:0]    count_q;
	logic [2:0]    lane_q;
	logic [2:0]    sent_q;
	logic [7:0]    bytes_q [BYTE_LANES];
	logic [AW-1:0] head_q;
	logic [OW-1:0] occ_q;

	logic [CW-1:0] cap_ext;
	logic [CW-1:0] cap_lim;
	logic          room;
	logic [2:0]    drain_lim;
	logic [2:0]    count_sat;
	logic [OW:0]   tail_sum;
	logic [OW:0]   tail_wrap;
	logic [AW-1:0] head_next;
	logic          in_lanes;
	logic          can_send;
	logic [7:0]    cur_byte;
	logic          step;
	logic          finish;
	logic          accept;

	assign cap_ext   = CW'(capacity);
	assign cap_lim   = (cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext;
	assign room      = CW'(occ_q) < cap_lim;
	assign drain_lim = (drain > 3'(DRAIN_MAX)) ? 3'(DRAIN_MAX) : drain;
	assign count_sat = (arrival_count > 3'(LANES)) ? 3'(LANES) : arrival_count;

	// tail = head + occupancy, folded once into the ring
	assign tail_sum  = (OW + 1)'(head_q) + (OW + 1)'(occ_q);
	assign tail_wrap = (tail_sum >= (OW + 1)'(DEPTH)) ? tail_sum - (OW + 1)'(DEPTH) : tail_sum;
	assign head_next = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	assign in_lanes = lane_q < count_q;
	assign can_send = (sent_q < drain_lim) && (occ_q != '0);
	assign cur_byte = bytes_q[lane_q[LANE_W-1:0]];

	assign mem_waddr = AW'(tail_wrap);
	assign mem_wdata = cur_byte;
	assign mem_raddr = head_q;

	always_comb begin
		emit   = 1'b0;
		desc   = '0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		if (busy_q) begin
			if (in_lanes) begin
				if (room) begin
					mem_we = advance;
				end else begin
					emit         = 1'b1;
					desc.kind    = KIND_DROPPED;
					desc.payload = cur_byte;
					desc.fill    = 5'(occ_q);
					desc.last    = (lane_q == count_q - 3'd1) &&
						((drain_lim == 3'd0) || (occ_q == '0));
				end
			end else if (can_send) begin
				mem_re        = advance;
				emit          = 1'b1;
				desc.kind     = KIND_SENT;
				desc.fill     = 5'(occ_q - OW'(1));
				desc.from_mem = 1'b1;
				desc.last     = (sent_q + 3'd1 == drain_lim) || (occ_q == OW'(1));
			end else begin
				emit      = 1'b1;
				desc.kind = KIND_IDLE;
				desc.fill = 5'(occ_q);
				desc.last = 1'b1;
			end
		end
	end

	assign step     = busy_q && advance;
	assign finish   = step && emit && desc.last;
	assign in_ready = !busy_q || finish;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			lane_q <= '0;
			sent_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			lane_q <= '0;
			sent_q <= '0;
		end else if (step) begin
			if (finish) begin
				busy_q <= 1'b0;
			end
			if (in_lanes) begin
				lane_q <= lane_q + 3'd1;
			end else if (can_send) begin
				sent_q <= sent_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
		end else if (step) begin
			if (in_lanes && room) begin
				occ_q <= occ_q + OW'(1);
			end else if (!in_lanes && can_send) begin
				occ_q  <= occ_q - OW'(1);
				head_q <= head_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			count_q    <= count_sat;
			bytes_q[0] <= byte_zero;
			bytes_q[1] <= byte_one;
			bytes_q[2] <= byte_two;
			bytes_q[3] <= byte_three;
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(DEPTH))
		else $error("occupancy above ring depth");

	a_sent_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (sent_q <= 3'(DRAIN_MAX)))
		else $error("more bytes sent than the drain limit");

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && !in_valid) |=> !busy_q)
		else $error("sequencer still busy after the last result of a tick");

endmodule

FILE: src/leaky_bucket_shaper.sv
// Top level of the leaky bucket shaper: config port, sequencer, ring store, output stage.
//
// Each item is one time tick with up to four arriving bytes. In lane order a byte is
// written into the ring if the fill is below the capacity, capped at the ring depth;
// else it leaves at once as a dropped result. Then up to drain_rate bytes, at most four,
// leave from the head as sent results, and a tick with neither gives one idle result.
// The last result of a tick has last set. The sequencer takes a step for each arriving
// byte and each sent byte, and one more for the idle result when the tick neither sends
// nor drops; each step makes at most one ring access. Every step, a store included,
// waits while the result register is full and out_ready is low. The next item is taken
// in the cycle that issues the final result of the current one. Results wait in a result
// register, but out_ready reaches the sequencer combinationally, and a step that stores
// a byte gives no result. A sent byte is read from the ring in the cycle before it shows
// on the output. The ring has no reset; only bytes that were written are ever read.
// Configuration is an APB slave with bucket_capacity at byte address 0 and drain_rate
// at 4; it must be written only while idle, and the block itself does not enforce this.
module leaky_bucket_shaper import lbs_pkg::*; #(
	parameter int BUFFER_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  arrival_count,
	input  logic [7:0]  byte_zero,
	input  logic [7:0]  byte_one,
	input  logic [7:0]  byte_two,
	input  logic [7:0]  byte_three,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  payload,
	output logic [4:0]  fill_level,
	output logic        last
);

	localparam int AW = $clog2(BUFFER_DEPTH);

	logic [4:0] cap_q;
	logic [2:0] drain_q;
	logic       cfg_wr;

	logic          advance;
	logic          emit;
	result_t       desc;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	logic    out_v_s2;
	result_t desc_s2;

	// Configuration port: always ready, register picked by address bit 2.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			drain_q <= DRAIN_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_CAPACITY: cap_q   <= pwdata[4:0];
				REG_DRAIN:    drain_q <= pwdata[2:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_CAPACITY: prdata = {27'd0, cap_q};
			REG_DRAIN:    prdata = {29'd0, drain_q};
			default:      prdata = '0;
		endcase
	end

	// Advance the sequencer whenever the result register is free or being emptied.
	assign advance = !out_v_s2 || out_ready;

	lbs_seq #(
		.DEPTH(BUFFER_DEPTH)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.arrival_count(arrival_count),
		.byte_zero    (byte_zero),
		.byte_one     (byte_one),
		.byte_two     (byte_two),
		.byte_three   (byte_three),
		.capacity     (cap_q),
		.drain        (drain_q),
		.advance      (advance),
		.emit         (emit),
		.desc         (desc),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr)
	);

	lbs_ring #(
		.DEPTH(BUFFER_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Result register: a sent byte takes its payload from the ring read data, which
	// holds steady while the result waits, since no read is issued during a stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s2 <= 1'b0;
		end else if (advance) begin
			out_v_s2 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			desc_s2 <= desc;
		end
	end

	assign out_valid  = out_v_s2;
	assign kind       = desc_s2.kind;
	assign payload    = desc_s2.from_mem ? mem_rdata : desc_s2.payload;
	assign fill_level = desc_s2.fill;
	assign last       = desc_s2.last;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the leaky bucket shaper: directed table, random phases, predictor.
module testbench import lbs_pkg::*; ();

	localparam int  BUFFER_DEPTH  = 16;
	localparam int  SETTLE_CYCLES = 12;     // covers the longest tick plus the output stage
	localparam int  LONG_HOLD     = 150;    // receiver hold-off long enough to back up the input
	localparam int  PHASE_ITEMS   = 14;
	localparam int  CYCLE_LIMIT   = 100000;

	// one result of a tick, as the predictor produces it
	typedef struct packed {
		kind_t      kind;
		logic [7:0] payload;
		logic [4:0] fill;
		logic       last;
	} shaped_t;

	typedef enum logic [1:0] {
		ROW_TICK,
		ROW_SET_CAPACITY,
		ROW_SET_DRAIN
	} row_op_t;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	// one row of the directed table: a tick, or a register write while idle
	typedef struct {
		row_op_t         op;
		logic [2:0]      count;
		logic [3:0][7:0] lanes;     // lane 0 in the low byte
		logic [31:0]     value;
		bit              typed;     // single result given below, else taken from the predictor
		shaped_t         want;
	} stim_row_t;

	localparam shaped_t UNTYPED = '{KIND_SENT, 8'h00, 5'd0, 1'b0};

	// Start at the reset settings (capacity 10, one byte per tick), fill the bucket, overflow
	// it, then walk the extremes: no drain, drain above four, capacity zero, capacity above
	// the ring, and a tick with four drops and four sends.
	stim_row_t directed_rows [25] = '{
		'{ROW_TICK,         3'd0, 32'h0000_0000, 32'd0,  1'b1, '{KIND_IDLE, 8'h00, 5'd0, 1'b1}},
		'{ROW_TICK,         3'd1, 32'h0000_00FF, 32'd0,  1'b1, '{KIND_SENT, 8'hFF, 5'd0, 1'b1}},
		'{ROW_TICK,         3'd1, 32'hFFFF_FF00, 32'd0,  1'b1, '{KIND_SENT, 8'h00, 5'd0, 1'b1}},
		'{ROW_TICK,         3'd4, 32'h00FF_5AA5, 32'd0,  1'b1, '{KIND_SENT, 8'hA5, 5'd3, 1'b1}},
		'{ROW_TICK,         3'd7, 32'h4433_2211, 32'd0,  1'b0, UNTYPED},
		'{ROW_TICK,         3'd5, 32'h8877_6655, 32'd0,  1'b0, UNTYPED},
		'{ROW_TICK,         3'd4, 32'hDDCC_BBAA, 32'd0,  1'b0, UNTYPED},
		'{ROW_SET_DRAIN,    3'd0, 32'h0000_0000, 32'd0,  1'b0, UNTYPED},
		'{ROW_TICK,         3'd4, 32'h0403_0201, 32'd0,  1'b0, UNTYPED},
		'{ROW_TICK,         3'd0, 32'hFFFF_FFFF, 32'd0,  1'b0, UNTYPED},
		'{ROW_SET_DRAIN,    3'd0, 32'h0000_0000, 32'd7,  1'b0, UNTYPED},
		'{ROW_TICK,         3'd0, 32'h0000_0000, 32'd0,  1'b0, UNTYPED},
		'{ROW_SET_CAPACITY, 3'd0, 32'h0000_0000, 32'd0,  1'b0, UNTYPED},
		'{ROW_TICK,         3'd4, 32'hF0E0_D0C0, 32'd0,  1'b0, UNTYPED},
		'{ROW_TICK,         3'd0, 32'h0000_0000, 32'd0,  1'b0, UNTYPED},
		'{ROW_TICK,         3'd2, 32'h0000_7F80, 32'd0,  1'b0, UNTYPED},
		'{ROW_SET_CAPACITY, 3'd0, 32'h0000_0000, 32'd31, 1'b0, UNTYPED},
		'{ROW_SET_DRAIN,    3'd0, 32'h0000_0000, 32'd0,  1'b0, UNTYPED},
		'{ROW_TICK,         3'd4, 32'h1312_1110, 32'd0,  1'b0, UNTYPED},
		'{ROW_TICK,         3'd4, 32'h2322_2120, 32'd0,  1'b0, UNTYPED},
		'{ROW_TICK,         3'd4, 32'h3332_3130, 32'd0,  1'b0, UNTYPED},
		'{ROW_TICK,         3'd4, 32'h4342_4140, 32'd0,  1'b0, UNTYPED},
		'{ROW_TICK,         3'd4, 32'hE7C3_8155, 32'd0,  1'b0, UNTYPED},
		'{ROW_SET_DRAIN,    3'd0, 32'h0000_0000, 32'd4,  1'b0, UNTYPED},
		'{ROW_TICK,         3'd4, 32'h0F1E_2D3C, 32'd0,  1'b0, UNTYPED}
	};

	// random phases: -1 picks a random setting; every phase writes both registers
	int         phase_cap  [8] = '{16, 31, 0, -1, 5, -1, -1, 1};
	int         phase_rate [8] = '{1, 7, 2, -1, 3, -1, -1, 4};
	idle_mode_t phase_mode [8] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
	                               IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  arrival_count = '0;
	logic [7:0]  byte_zero = '0;
	logic [7:0]  byte_one = '0;
	logic [7:0]  byte_two = '0;
	logic [7:0]  byte_three = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  payload;
	logic [4:0]  fill_level;
	logic        last;

	// predictor state: its own ring, head, fill and register copies
	logic [7:0]  ring_bytes [BUFFER_DEPTH];
	logic [3:0]  ring_head = '0;
	int          bucket_fill = 0;
	logic [4:0]  capacity_reg = CAP_RESET;
	logic [2:0]  drain_reg = DRAIN_RESET;

	shaped_t     tick_results [$];      // results of the tick just predicted
	shaped_t     pending_results [$];   // results still awaited from the block, oldest first

	idle_mode_t  traffic_mode = IDLE_BOTH;
	int unsigned hold_requests = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	leaky_bucket_shaper #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.arrival_count(arrival_count),
		.byte_zero(byte_zero),
		.byte_one(byte_one),
		.byte_two(byte_two),
		.byte_three(byte_three),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.payload(payload),
		.fill_level(fill_level),
		.last(last)
	);

	always #6 clk = ~clk;

	// Decide whether a side sits out this cycle under the current traffic mode.
	function automatic bit roll_idle(input bit sender);
		case (traffic_mode)
			IDLE_NONE: return 1'b0;
			IDLE_SEND: return sender && ($urandom_range(99) < 75);
			IDLE_RECV: return !sender && ($urandom_range(99) < 75);
			default:   return $urandom_range(99) < 28;
		endcase
	endfunction

	function automatic void add_result(input kind_t k, input logic [7:0] b);
		tick_results.push_back('{k, b, 5'(bucket_fill), 1'b0});
	endfunction

	// Advance the shaper by one tick: store or drop each arrival in lane order, drain from
	// the head, fall back to an idle result, and mark the final result of the tick.
	task automatic shape_tick(input logic [2:0] count, input logic [3:0][7:0] lanes);
		int arrivals;
		int cap;
		int rate;
		int tail;
		tick_results.delete();
		arrivals = (count > LANES) ? LANES : count;
		cap      = (capacity_reg > BUFFER_DEPTH) ? BUFFER_DEPTH : capacity_reg;
		rate     = (drain_reg > DRAIN_MAX) ? DRAIN_MAX : drain_reg;
		for (int i = 0; i < arrivals; i++) begin
			if (bucket_fill < cap) begin
				tail = (ring_head + bucket_fill) % BUFFER_DEPTH;
				ring_bytes[tail] = lanes[i];
				bucket_fill++;
			end else begin
				add_result(KIND_DROPPED, lanes[i]);
			end
		end
		for (int i = 0; i < rate && bucket_fill > 0; i++) begin
			ring_head = ring_head + 4'd1;
			bucket_fill--;
			add_result(KIND_SENT, ring_bytes[ring_head - 4'd1]);
		end
		if (tick_results.size() == 0)
			add_result(KIND_IDLE, 8'h00);
		tick_results[tick_results.size() - 1].last = 1'b1;
	endtask

	// Offer one tick, after an optional gap, and hold it until the block takes it.
	// Valid is left high on acceptance; the next offer or a settle decides what follows.
	task automatic offer_tick(input logic [2:0] count, input logic [3:0][7:0] lanes,
	                          input bit typed, input shaped_t want);
		if (roll_idle(1'b1)) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (roll_idle(1'b1));
		end
		in_valid      <= 1'b1;
		arrival_count <= count;
		byte_zero     <= lanes[0];
		byte_one      <= lanes[1];
		byte_two      <= lanes[2];
		byte_three    <= lanes[3];
		shape_tick(count, lanes);
		if (typed)
			pending_results.push_back(want);
		else
			foreach (tick_results[i])
				pending_results.push_back(tick_results[i]);
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid, wait for every awaited result, then let the block go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the register takes the value on that edge.
	// The bus then returns to idle before the task ends, so a following write starts on a later edge.
	task automatic reg_write(input logic idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_CAPACITY)
			capacity_reg = value[4:0];
		else
			drain_reg = value[2:0];
		@(posedge clk);
	endtask

	// Receiver: random stalls by mode, plus a long hold-off counted here whenever the
	// stimulus asks for one, so the block backs up and stalls its input.
	always @(posedge clk) begin
		int unsigned hold_left;
		int unsigned holds_served;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_requests != holds_served) begin
			holds_served = hold_requests;
			hold_left    = LONG_HOLD;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !roll_idle(1'b0);
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want,
	                                    input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Compare each result taken from the block with the oldest one awaited.
	always @(posedge clk) begin
		shaped_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0h payload %0h",
				         $time, kind, payload);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 8'(want.kind), 8'(kind));
				check_field("payload", want.payload, payload);
				check_field("fill_level", 8'(want.fill), 8'(fill_level));
				check_field("last", 8'(want.last), 8'(last));
			end
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** leaky_bucket_shaper: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		logic [2:0]      count;
		logic [3:0][7:0] lanes;
		logic [4:0]      cap_val;
		logic [2:0]      rate_val;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part, under light idling on both sides
		foreach (directed_rows[r]) begin
			case (directed_rows[r].op)
				ROW_TICK: begin
					offer_tick(directed_rows[r].count, directed_rows[r].lanes,
					           directed_rows[r].typed, directed_rows[r].want);
				end
				ROW_SET_CAPACITY: begin
					settle();
					reg_write(REG_CAPACITY, directed_rows[r].value);
				end
				default: begin
					settle();
					reg_write(REG_DRAIN, directed_rows[r].value);
				end
			endcase
		end

		// random phases, each with its own settings and idling pattern
		for (int ph = 0; ph < 8; ph++) begin
			cap_val  = (phase_cap[ph] < 0) ? 5'($urandom_range(31)) : 5'(phase_cap[ph]);
			rate_val = (phase_rate[ph] < 0) ? 3'($urandom_range(7)) : 3'(phase_rate[ph]);
			settle();
			reg_write(REG_CAPACITY, 32'(cap_val));
			reg_write(REG_DRAIN, 32'(rate_val));
			traffic_mode = phase_mode[ph];
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// hold the receiver off for a long stretch while ticks keep coming
				if (ph == 4 && k == 2)
					hold_requests++;
				// pause the sender until everything awaited has arrived
				if (ph == 5 && k == 8)
					settle();
				count = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
				                                 : 3'($urandom_range(4));
				lanes = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
				offer_tick(count, lanes, 1'b0, UNTYPED);
			end
		end

		settle();
		if (mismatches == 0)
			$display("** leaky_bucket_shaper: PASSED **");
		else
			$display("** leaky_bucket_shaper: FAILED **");
		$finish;
	end

endmodule
